// File: rtl/tef64_pkg.sv
// ----------------------------------------------------------------------------
// tef64_pkg: shared types and constants
// Source format codes, field widths and the decode bundle passed between the
// decode and rounding stages of the element converter.
// ----------------------------------------------------------------------------
package tef64_pkg;

  localparam int unsigned ElemW = 64;
  localparam int unsigned FmtW  = 4;

  typedef logic [ElemW-1:0] elem_t;
  typedef logic [FmtW-1:0]  fmt_t;

  // Source format codes
  localparam fmt_t FMT_F64  = 4'd0;
  localparam fmt_t FMT_F32  = 4'd1;
  localparam fmt_t FMT_F16  = 4'd2;
  localparam fmt_t FMT_BF16 = 4'd3;
  localparam fmt_t FMT_I8   = 4'd4;
  localparam fmt_t FMT_U8   = 4'd5;
  localparam fmt_t FMT_I16  = 4'd6;
  localparam fmt_t FMT_I32  = 4'd7;
  localparam fmt_t FMT_I64  = 4'd8;
  localparam fmt_t FMT_U16  = 4'd9;
  localparam fmt_t FMT_U32  = 4'd10;
  localparam fmt_t FMT_U64  = 4'd11;
  localparam fmt_t FMT_BOOL = 4'd12;

  // Decoded element: either a finished pattern or a sign/magnitude integer
  typedef struct packed {
    logic  is_int;  // magnitude still needs normalize and round
    logic  sign;
    elem_t bits;    // finished pattern, or integer magnitude
  } dec_t;

endpackage

// File: rtl/tef64_if.sv
// ----------------------------------------------------------------------------
// tef64_if: valid/ready stream channel
// Carries one 64-bit word per item between a source and a sink.
// ----------------------------------------------------------------------------
interface tef64_if;
  logic        valid;
  logic        ready;
  logic [63:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/tef64_decode.sv
// ----------------------------------------------------------------------------
// tef64_decode: format decode and float widening
// Widens narrow floats to binary64 and extracts sign/magnitude for integers.
// ----------------------------------------------------------------------------
module tef64_decode (
  input  tef64_pkg::fmt_t  fmt_i,
  input  tef64_pkg::elem_t elem_i,
  output tef64_pkg::dec_t  dec_o
);
  import tef64_pkg::*;

  // f16 subnormal: leading-zero count of the 10-bit fraction
  logic [9:0]  h_frac;
  logic [3:0]  h_lz;
  logic [9:0]  h_norm;
  logic [63:0] f32_w, f16_w, bf16_w;

  assign h_frac = elem_i[9:0];

  always_comb begin
    h_lz = 4'd0;
    for (int i = 0; i < 10; i++) begin
      if (h_frac[i]) h_lz = 4'(9 - i);
    end
  end

  assign h_norm = 10'(h_frac << (h_lz + 4'd1));

  // f32 widening (f32 subnormals never reach a binary64 subnormal, but
  // the model normalizes them too)
  logic [22:0] s_frac;
  logic [4:0]  s_lz;
  logic [22:0] s_norm;
  assign s_frac = elem_i[22:0];
  always_comb begin
    s_lz = 5'd0;
    for (int i = 0; i < 23; i++) begin
      if (s_frac[i]) s_lz = 5'(22 - i);
    end
  end
  assign s_norm = 23'(s_frac << (s_lz + 5'd1));

  logic [6:0] b_frac;
  logic [2:0] b_lz;
  logic [6:0] b_norm;
  assign b_frac = elem_i[6:0];
  always_comb begin
    b_lz = 3'd0;
    for (int i = 0; i < 7; i++) begin
      if (b_frac[i]) b_lz = 3'(6 - i);
    end
  end
  assign b_norm = 7'(b_frac << (b_lz + 3'd1));

  always_comb begin
    logic [7:0] e8;
    logic [4:0] e5;
    e8 = elem_i[30:23];
    if (e8 == 8'd0) begin
      if (s_frac == '0) f32_w = {elem_i[31], 63'd0};
      else f32_w = {elem_i[31], 11'(11'd896 - 11'(s_lz)), s_norm, 29'd0};
    end else if (e8 == 8'hFF) begin
      f32_w = {elem_i[31], 11'h7FF, (s_frac != '0), s_frac[21:0], 29'd0};
      if (s_frac == '0) f32_w = {elem_i[31], 11'h7FF, 52'd0};
      else f32_w = {elem_i[31], 11'h7FF, s_frac[22] | 1'b1, s_frac[21:0], 29'd0};
    end else begin
      f32_w = {elem_i[31], 11'(11'(e8) + 11'd896), s_frac, 29'd0};
    end

    e5 = elem_i[14:10];
    if (e5 == 5'd0) begin
      if (h_frac == '0) f16_w = {elem_i[15], 63'd0};
      else f16_w = {elem_i[15], 11'(11'd1008 - 11'(h_lz)), h_norm, 42'd0};
    end else if (e5 == 5'h1F) begin
      if (h_frac == '0) f16_w = {elem_i[15], 11'h7FF, 52'd0};
      else f16_w = {elem_i[15], 11'h7FF, 1'b1, h_frac[8:0], 42'd0};
    end else begin
      f16_w = {elem_i[15], 11'(11'(e5) + 11'd1008), h_frac, 42'd0};
    end

    e8 = elem_i[14:7];
    if (e8 == 8'd0) begin
      if (b_frac == '0) bf16_w = {elem_i[15], 63'd0};
      else bf16_w = {elem_i[15], 11'(11'd896 - 11'(b_lz)), b_norm, 45'd0};
    end else if (e8 == 8'hFF) begin
      if (b_frac == '0) bf16_w = {elem_i[15], 11'h7FF, 52'd0};
      else bf16_w = {elem_i[15], 11'h7FF, 1'b1, b_frac[5:0], 45'd0};
    end else begin
      bf16_w = {elem_i[15], 11'(11'(e8) + 11'd896), b_frac, 45'd0};
    end
  end

  // Format select
  always_comb begin
    dec_o = '{is_int: 1'b1, sign: 1'b0, bits: '0};
    case (fmt_i)
      FMT_F64:  dec_o = '{is_int: 1'b0, sign: 1'b0, bits: elem_i};
      FMT_F32:  dec_o = '{is_int: 1'b0, sign: 1'b0, bits: f32_w};
      FMT_F16:  dec_o = '{is_int: 1'b0, sign: 1'b0, bits: f16_w};
      FMT_BF16: dec_o = '{is_int: 1'b0, sign: 1'b0, bits: bf16_w};
      FMT_I8: begin
        dec_o.sign = elem_i[7];
        dec_o.bits = elem_i[7] ? 64'(8'(-elem_i[7:0])) : 64'(elem_i[7:0]);
      end
      FMT_U8, FMT_BOOL: dec_o.bits = 64'(elem_i[7:0]);
      FMT_I16: begin
        dec_o.sign = elem_i[15];
        dec_o.bits = elem_i[15] ? 64'(16'(-elem_i[15:0])) : 64'(elem_i[15:0]);
      end
      FMT_I32: begin
        dec_o.sign = elem_i[31];
        dec_o.bits = elem_i[31] ? 64'(32'(-elem_i[31:0])) : 64'(elem_i[31:0]);
      end
      FMT_I64: begin
        dec_o.sign = elem_i[63];
        dec_o.bits = elem_i[63] ? 64'(-elem_i) : elem_i;
      end
      FMT_U16: dec_o.bits = 64'(elem_i[15:0]);
      FMT_U32: dec_o.bits = 64'(elem_i[31:0]);
      FMT_U64: dec_o.bits = elem_i;
      default: dec_o = '{is_int: 1'b0, sign: 1'b0, bits: '0};
    endcase
  end
endmodule

// File: rtl/tef64_round.sv
// ----------------------------------------------------------------------------
// tef64_round: integer normalize and round
// Leading-one count, shift and round-to-nearest-even of a 64-bit magnitude.
// ----------------------------------------------------------------------------
module tef64_round (
  input  tef64_pkg::dec_t  dec_i,
  output tef64_pkg::elem_t res_o
);
  import tef64_pkg::*;

  logic [5:0]  msb;
  logic [63:0] norm;      // leading one at bit 63
  logic [52:0] keep;
  logic        grd, stk;
  logic [53:0] rnd;
  logic [10:0] ex;

  // Leading-one position
  always_comb begin
    msb = 6'd0;
    for (int i = 0; i < 64; i++) begin
      if (dec_i.bits[i]) msb = 6'(i);
    end
  end

  assign norm = dec_i.bits << (6'd63 - msb);
  assign keep = norm[63:11];
  assign grd  = norm[10];
  assign stk  = |norm[9:0];
  assign rnd  = {1'b0, keep} + 54'(grd & (stk | keep[0]));

  always_comb begin
    ex = 11'(11'd1023 + 11'(msb));
    if (!dec_i.is_int) begin
      res_o = dec_i.bits;
    end else if (dec_i.bits == '0) begin
      res_o = '0;
    end else if (rnd[53]) begin
      res_o = {dec_i.sign, 11'(ex + 11'd1), 52'd0};
    end else begin
      res_o = {dec_i.sign, ex, rnd[51:0]};
    end
  end
endmodule

// File: rtl/tensor_element_to_fp64_converter.sv
// ----------------------------------------------------------------------------
// tensor_element_to_fp64_converter: tensor element to binary64
// Path: an accepted item is held in the input reg, then in the result reg.
// Throughput: one item per cycle while the output is not stalled; the
// rounding path between the two registers sets the clock limit.
// Reset: clears both valid flags and sets the source format to f64.
// ----------------------------------------------------------------------------
module tensor_element_to_fp64_converter (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  tef64_pkg::fmt_t    cfg_wdata_i,
  tef64_if.sink              in_i,
  tef64_if.source            out_o
);
  import tef64_pkg::*;

  fmt_t  fmt_q;
  logic  s1_vld_q, s2_vld_q;
  elem_t s1_q, s2_q, s2_d;
  dec_t  dec;
  logic  s1_adv, s2_adv;

  // Pipeline flow: each stage takes a new item when empty or draining
  assign s2_adv   = !s2_vld_q || out_o.ready;
  assign s1_adv   = !s1_vld_q || s2_adv;
  assign in_i.ready = s1_adv;

  tef64_decode u_dec (.fmt_i(fmt_q), .elem_i(s1_q), .dec_o(dec));
  tef64_round  u_rnd (.dec_i(dec), .res_o(s2_d));

  // Configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q <= FMT_F64;
    end else if (cfg_we_i) begin
      fmt_q <= cfg_wdata_i;
    end
  end

  // Valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
    end else begin
      if (s1_adv) s1_vld_q <= in_i.valid;
      if (s2_adv) s2_vld_q <= s1_vld_q;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (s1_adv && in_i.valid) s1_q <= in_i.data;
    if (s2_adv && s1_vld_q) s2_q <= s2_d;
  end

  assign out_o.valid = s2_vld_q;
  assign out_o.data  = s2_q;

  // Stalled result is held
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_vld_q && !out_o.ready |=> s2_vld_q && $stable(s2_q))
    else $error("result changed while stalled");
  // Input stage never dropped while output stalls
  a_s1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_vld_q && !s2_adv |=> s1_vld_q)
    else $error("input stage lost an item");
  // Accepted item is registered in the input stage
  a_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready |=> s1_vld_q)
    else $error("accepted item not registered");
endmodule

// File: sim/tb.sv
// ----------------------------------------------------------------------------
// tb: testbench for tensor_element_to_fp64_converter
// Streams raw elements in every source format through the converter, with
// random gaps on both sides, and checks each binary64 result against a
// behavioral widening and integer-rounding model kept in this file.
// ----------------------------------------------------------------------------
module tb;
  import tef64_pkg::*;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned DrainCycles = 8;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  fmt_t cfg_wdata_i;

  tef64_if elem_ch ();
  tef64_if fp64_ch ();

  tensor_element_to_fp64_converter dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (elem_ch.sink),
    .out_o       (fp64_ch.source)
  );

  // Clock
  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  elem_t pending_elems[$];
  elem_t expected_fp64[$];
  fmt_t  cur_fmt;
  int unsigned error_count;
  int unsigned cycle_count;
  int unsigned long_hold;
  bit          sender_pause;
  bit          in_taken;

  // Widen a narrow binary float; ew exponent bits, fw fraction bits.
  function automatic elem_t widen_narrow(logic sgn, int unsigned ex, elem_t frac,
                                         int unsigned ew, int unsigned fw);
    int unsigned bias;
    int unsigned emax;
    int unsigned k;
    elem_t fmask;
    elem_t s;
    bias  = (1 << (ew - 1)) - 1;
    emax  = (1 << ew) - 1;
    fmask = (64'd1 << fw) - 64'd1;
    s     = {sgn, 63'd0};
    frac  = frac & fmask;
    k     = 0;
    if (ex == 0) begin
      if (frac == 0) return s;
      while ((frac & (64'd1 << fw)) == 0) begin
        frac = frac << 1;
        k++;
      end
      frac = frac & fmask;
      return s | (elem_t'(1024 - bias - k) << 52) | (frac << (52 - fw));
    end
    if (ex == emax) begin
      if (frac == 0) return s | (64'h7FF << 52);
      return s | (64'h7FF << 52) | 64'h0008_0000_0000_0000 | (frac << (52 - fw));
    end
    return s | (elem_t'(ex - bias + 1023) << 52) | (frac << (52 - fw));
  endfunction

  // Sign and magnitude to binary64, nearest even.
  function automatic elem_t mag_to_fp64(logic sgn, elem_t mag);
    int unsigned p;
    int unsigned sh;
    elem_t keep;
    elem_t rem;
    elem_t half;
    if (mag == 0) return '0;
    p = 63;
    while ((mag >> p) == 0) p--;
    if (p <= 52) begin
      keep = mag << (52 - p);
    end else begin
      sh   = p - 52;
      rem  = mag & ((64'd1 << sh) - 64'd1);
      half = 64'd1 << (sh - 1);
      keep = mag >> sh;
      if (rem > half || (rem == half && keep[0])) keep++;
      if ((keep >> 53) != 0) begin
        keep = keep >> 1;
        p++;
      end
    end
    return {sgn, 63'd0} | (elem_t'(1023 + p) << 52) | (keep & 64'h000F_FFFF_FFFF_FFFF);
  endfunction

  function automatic elem_t signed_to_fp64(elem_t v, int unsigned w);
    elem_t mask;
    mask = (w >= 64) ? '1 : ((64'd1 << w) - 64'd1);
    v = v & mask;
    if (v[w-1]) return mag_to_fp64(1'b1, (64'd0 - v) & mask);
    return mag_to_fp64(1'b0, v);
  endfunction

  function automatic elem_t convert_elem(fmt_t f, elem_t b);
    case (f)
      FMT_F64:  return b;
      FMT_F32:  return widen_narrow(b[31], b[30:23], 64'(b[22:0]), 8, 23);
      FMT_F16:  return widen_narrow(b[15], b[14:10], 64'(b[9:0]), 5, 10);
      FMT_BF16: return widen_narrow(b[15], b[14:7], 64'(b[6:0]), 8, 7);
      FMT_I8:   return signed_to_fp64(b, 8);
      FMT_U8, FMT_BOOL: return mag_to_fp64(1'b0, 64'(b[7:0]));
      FMT_I16:  return signed_to_fp64(b, 16);
      FMT_I32:  return signed_to_fp64(b, 32);
      FMT_I64:  return signed_to_fp64(b, 64);
      FMT_U16:  return mag_to_fp64(1'b0, 64'(b[15:0]));
      FMT_U32:  return mag_to_fp64(1'b0, 64'(b[31:0]));
      FMT_U64:  return mag_to_fp64(1'b0, b);
      default:  return '0;
    endcase
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 45) return 0;
    if (r < 90) return $urandom_range(3, 1);
    return $urandom_range(25, 6);
  endfunction

  function automatic elem_t rand_elem();
    elem_t e;
    e = {$urandom, $urandom};
    // Bias toward edge patterns now and then
    case ($urandom_range(7))
      0: e = e & 64'hFF;
      1: e = e | 64'hFFFF_FFFF_FFFF_FF00;
      2: e = e & 64'h0000_0000_0000_807F;
      3: e = e | 64'h0000_0000_7F80_7C00;
      default: ;
    endcase
    return e;
  endfunction

  // Input handshake seen at the rising edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= elem_ch.valid && elem_ch.ready;
    end
  end

  // Driver: offers queued items, with random gaps
  int unsigned send_gap;
  always @(negedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      elem_ch.valid <= 1'b0;
      elem_ch.data  <= '0;
      send_gap      <= 0;
    end else if (elem_ch.valid && !in_taken) begin
      // hold the offered item
    end else if (elem_ch.valid && in_taken) begin
      // accepted at the last rising edge
      expected_fp64.push_back(convert_elem(cur_fmt, elem_ch.data));
      if (send_gap == 0 && !sender_pause && pending_elems.size() > 0) begin
        elem_ch.data  <= pending_elems.pop_front();
        elem_ch.valid <= 1'b1;
        send_gap      <= pick_gap();
      end else begin
        elem_ch.valid <= 1'b0;
      end
    end else if (send_gap != 0) begin
      send_gap <= send_gap - 1;
    end else if (!sender_pause && pending_elems.size() > 0) begin
      elem_ch.data  <= pending_elems.pop_front();
      elem_ch.valid <= 1'b1;
      send_gap      <= pick_gap();
    end
  end

  // Receiver ready, with random stalls and one long hold-off on request
  int unsigned stall_left;
  always @(negedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fp64_ch.ready <= 1'b0;
      stall_left    <= 0;
    end else if (long_hold != 0) begin
      fp64_ch.ready <= 1'b0;
      long_hold     <= long_hold - 1;
    end else if (stall_left != 0) begin
      fp64_ch.ready <= 1'b0;
      stall_left    <= stall_left - 1;
    end else begin
      fp64_ch.ready <= 1'b1;
      if ($urandom_range(3) == 0) stall_left <= pick_gap();
    end
  end

  // Monitor: checks each accepted result
  always @(posedge clk_i) begin
    if (rst_ni && fp64_ch.valid && fp64_ch.ready) begin
      if (expected_fp64.size() == 0) begin
        $error("result_bits: unexpected result %h", fp64_ch.data);
        error_count++;
      end else begin
        elem_t want;
        want = expected_fp64.pop_front();
        if (fp64_ch.data !== want) begin
          $error("result_bits: expected %h actual %h", want, fp64_ch.data);
          error_count++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic wait_drained();
    while (pending_elems.size() != 0 || elem_ch.valid || expected_fp64.size() != 0)
      @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic set_format(fmt_t f);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= f;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    cur_fmt     = f;
  endtask

  // Directed elements, the same set for every format
  task automatic load_directed(fmt_t f);
    pending_elems.push_back('0);
    pending_elems.push_back('1);
    pending_elems.push_back(64'h8000_0000_0000_0000);
    pending_elems.push_back(64'h7FFF_FFFF_FFFF_FFFF);
    pending_elems.push_back(64'h0000_0000_0000_0001);
    pending_elems.push_back(64'hFFFF_FFFF_FFFF_FF80); // i8 min, high bits set
    pending_elems.push_back(64'h0000_0000_0000_8000);
    pending_elems.push_back(64'h0000_0000_0000_7C00); // f16 inf
    pending_elems.push_back(64'h0000_0000_0000_7E01); // f16 nan
    pending_elems.push_back(64'h0000_0000_0000_03FF); // f16 subnormal
    pending_elems.push_back(64'h0000_0000_7F80_0000); // f32 inf
    pending_elems.push_back(64'h0000_0000_7F80_0001); // f32 signaling nan
    pending_elems.push_back(64'h0000_0000_0000_0001); // f32 min subnormal
    pending_elems.push_back(64'h0000_0000_0000_7F81); // bf16 nan
    pending_elems.push_back(64'h7FF0_0000_0000_0001); // f64 signaling nan
    pending_elems.push_back(64'h0020_0000_0000_0001); // 2^53 + 1, tie to even
    pending_elems.push_back(64'h0020_0000_0000_0003); // tie, rounds up
    pending_elems.push_back(64'hFFFF_FFFF_FFFF_FC00); // carry into exponent
    pending_elems.push_back(64'h0000_0000_8000_0000); // i32 min
  endtask

  initial begin
    fmt_t fmt_order[$];
    int unsigned n;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = FMT_F64;
    cur_fmt       = FMT_F64;
    elem_ch.valid = 1'b0;
    elem_ch.data  = '0;
    fp64_ch.ready = 1'b0;
    error_count   = 0;
    cycle_count   = 0;
    long_hold     = 0;
    sender_pause  = 1'b0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed pass at reset format, then every format incl. undefined codes 13 and 15
    load_directed(FMT_F64);
    wait_drained();
    fmt_order = '{FMT_F32, FMT_F16, FMT_BF16, FMT_I8, FMT_U8, FMT_I16, FMT_I32,
                  FMT_I64, FMT_U16, FMT_U32, FMT_U64, FMT_BOOL, fmt_t'(13), fmt_t'(15)};
    foreach (fmt_order[i]) begin
      set_format(fmt_order[i]);
      load_directed(fmt_order[i]);
      wait_drained();
    end

    // Random phases over each format in turn, then random formats, two of them with pressure
    for (int ph = 0; ph < 22; ph++) begin
      set_format(ph < 13 ? fmt_t'(ph) : fmt_t'($urandom_range(15)));
      n = 12;
      for (int k = 0; k < n; k++) pending_elems.push_back(rand_elem());
      if (ph == 3) long_hold = 60;
      if (ph == 8) begin
        // sender stops until every result is back, then resumes
        while (pending_elems.size() > 6) @(posedge clk_i);
        sender_pause = 1'b1;
        while (elem_ch.valid || expected_fp64.size() != 0) @(posedge clk_i);
        sender_pause = 1'b0;
      end
      wait_drained();
    end

    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/tef64_pkg.sv
rtl/tef64_if.sv
rtl/tef64_decode.sv
rtl/tef64_round.sv
rtl/tensor_element_to_fp64_converter.sv
sim/tb.sv
